@@ rtl/itrd_pkg.sv @@
`default_nettype none

package itrd_pkg;

    localparam int VALUE_BITS = 31;
    localparam int MAX_DIGITS = 32;

    localparam int RADIX_W  = 6;
    localparam int REM_W    = 6;
    localparam int CHAR_W   = 7;
    localparam int ADDR_W   = $clog2(MAX_DIGITS);
    localparam int CNT_W    = $clog2(MAX_DIGITS + 1);
    localparam int BITCNT_W = $clog2(VALUE_BITS);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_NONE   = 7'h00;

    typedef struct packed {
        logic start;
        logic div_step;
        logic store;
        logic rd;
        logic emit;
        logic emit_bad;
    } t_cmd;

    typedef struct packed {
        logic radix_bad;
        logic div_last;
        logic more_digits;
        logic ptr_zero;
        logic out_free;
    } t_stat;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        if (d < REM_W'(10)) begin
            return CHAR_ZERO + dx;
        end else if (d < REM_W'(36)) begin
            return CHAR_LETTER + dx - CHAR_W'(10);
        end else begin
            return CHAR_NONE;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/itrd_ram.sv @@
`default_nettype none

module itrd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/itrd_dp.sv @@
`default_nettype none

module itrd_dp
    import itrd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic [RADIX_W-1:0]    i_radix,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic      [CHAR_W-1:0]     o_digit_char,
    output logic                       o_last,
    output logic                       o_bad_radix
);

    logic [VALUE_BITS-1:0] r_quot;
    logic [REM_W-1:0]      r_rem;
    logic [RADIX_W-1:0]    r_radix;
    logic [BITCNT_W-1:0]   r_bitcnt;
    logic [CNT_W-1:0]      r_cnt;
    logic [ADDR_W-1:0]     r_ptr;
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_out_char;
    logic                  r_out_last;
    logic                  r_out_bad;

    logic [REM_W:0]   n_trial;
    logic             n_ge;
    logic [REM_W-1:0] n_rem;
    logic [REM_W-1:0] ram_rdata;

    // One restoring-division step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        n_trial = {r_rem, r_quot[VALUE_BITS-1]};
        n_ge    = n_trial >= (REM_W + 1)'(r_radix);
        n_rem   = n_ge ? REM_W'(n_trial - (REM_W + 1)'(r_radix)) : REM_W'(n_trial);
    end

    itrd_ram #(
        .WIDTH (REM_W),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (r_rem),
        .i_re    (i_cmd.rd),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_cnt <= '0;
            end else if (i_cmd.store) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            if (i_cmd.emit || i_cmd.emit_bad) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (i_cmd.start) begin
            r_quot   <= i_value;
            r_radix  <= i_radix;
            r_rem    <= '0;
            r_bitcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quot   <= {r_quot[VALUE_BITS-2:0], n_ge};
            r_rem    <= n_rem;
            r_bitcnt <= r_bitcnt + BITCNT_W'(1);
        end else if (i_cmd.store) begin
            // restart the divider on the quotient for the next digit
            r_rem    <= '0;
            r_bitcnt <= '0;
        end

        if (i_cmd.store) begin
            r_ptr <= r_cnt[ADDR_W-1:0];
        end else if (i_cmd.emit && (r_ptr != '0)) begin
            r_ptr <= r_ptr - ADDR_W'(1);
        end

        if (i_cmd.emit) begin
            r_out_char <= digit_char(ram_rdata);
            r_out_last <= (r_ptr == '0);
            r_out_bad  <= 1'b0;
        end else if (i_cmd.emit_bad) begin
            r_out_char <= CHAR_NONE;
            r_out_last <= 1'b1;
            r_out_bad  <= 1'b1;
        end
    end

    always_comb begin
        o_stat.radix_bad   = (i_radix < RADIX_MIN) || (i_radix > RADIX_MAX);
        o_stat.div_last    = (r_bitcnt == BITCNT_W'(VALUE_BITS - 1));
        o_stat.more_digits = (r_quot != '0) && (r_cnt != CNT_W'(MAX_DIGITS - 1));
        o_stat.ptr_zero    = (r_ptr == '0);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last       = r_out_last;
    assign o_bad_radix  = r_out_bad;

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.emit_bad) |-> o_stat.out_free)
        else $error("output register loaded while holding an item");

    a_store_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> $past(i_cmd.div_step))
        else $error("remainder stored without a finished division");

    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (RADIX_W'(r_rem) < r_radix))
        else $error("stored remainder not below radix");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |=> (r_cnt <= CNT_W'(MAX_DIGITS)) && (r_cnt != '0))
        else $error("digit count out of range after store");
`endif

endmodule

`default_nettype wire

@@ rtl/itrd_ctrl.sv @@
`default_nettype none

module itrd_ctrl
    import itrd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_STORE,
        S_RD,
        S_EMIT,
        S_BAD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_stat.radix_bad ? S_BAD : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = i_stat.more_digits ? S_DIV : S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                // hold the fetched digit until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.ptr_zero ? S_IDLE : S_RD;
                end
            end
            S_BAD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_bad = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_bad_goes_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.start && i_stat.radix_bad) |=> (r_state == S_BAD))
        else $error("bad radix item did not take the error path");

    a_emit_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |=> (r_state == S_EMIT))
        else $error("store read not followed by emit");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

@@ rtl/integer_to_radix_digits.sv @@
`default_nettype none

// Converts a VALUE_BITS-bit unsigned value to ASCII digits ('0'-'9', 'A'-'Z') in a
// radix of 2 to 36, most significant digit first, with o_last on the final one; zero
// gives a single '0', and a radix outside 2..36 gives one item with o_bad_radix set and
// o_digit_char zero. One item is converted at a time. Each digit comes from the
// bit-serial restoring divider, one quotient bit a cycle, followed by a store of the
// remainder into the digit store, and each emitted character takes a registered read
// of the digit store before it is loaded into the output register.
// The next item is accepted as soon as the last character sits in the output register.

module integer_to_radix_digits
    import itrd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic [RADIX_W-1:0]    i_radix,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [CHAR_W-1:0]     o_digit_char,
    output logic                       o_last,
    output logic                       o_bad_radix
);

    t_cmd  cmd;
    t_stat stat;

    itrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    itrd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_digit_char (o_digit_char),
        .o_last       (o_last),
        .o_bad_radix  (o_bad_radix)
    );

endmodule

`default_nettype wire

@@ dv/integer_to_radix_digits_tb.sv @@
`default_nettype none

module integer_to_radix_digits_tb;
    import itrd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM     = 208;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TEXT,
        ROW_BAD_RADIX
    } t_row_kind;

    typedef struct packed {
        logic [VALUE_BITS-1:0]   value;
        logic [RADIX_W-1:0]      radix;
        t_row_kind               kind;
        logic [8*MAX_DIGITS-1:0] text;
    } t_stim_row;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              bad;
    } t_digit;

    localparam int N_DIR = 22;

    // Text rows hold the expected characters, most significant first.
    localparam t_stim_row DIR_ROWS [N_DIR] = '{
        '{31'd0,          6'd10, ROW_TEXT,      "0"},
        '{31'd0,          6'd2,  ROW_TEXT,      "0"},
        '{31'd0,          6'd36, ROW_TEXT,      "0"},
        '{31'h7FFFFFFF,   6'd2,  ROW_TEXT,      "1111111111111111111111111111111"},
        '{31'h7FFFFFFF,   6'd16, ROW_TEXT,      "7FFFFFFF"},
        '{31'h7FFFFFFF,   6'd36, ROW_TEXT,      "ZIK0ZJ"},
        '{31'h7FFFFFFF,   6'd10, ROW_TEXT,      "2147483647"},
        '{31'd35,         6'd36, ROW_TEXT,      "Z"},
        '{31'd1,          6'd2,  ROW_TEXT,      "1"},
        '{31'd255,        6'd2,  ROW_TEXT,      "11111111"},
        '{31'd36,         6'd36, ROW_TEXT,      "10"},
        '{31'd1295,       6'd36, ROW_TEXT,      "ZZ"},
        '{31'd9,          6'd10, ROW_TEXT,      "9"},
        '{31'd10,         6'd11, ROW_TEXT,      "A"},
        '{31'd0,          6'd0,  ROW_BAD_RADIX, ""},
        '{31'd5,          6'd1,  ROW_BAD_RADIX, ""},
        '{31'd7,          6'd37, ROW_BAD_RADIX, ""},
        '{31'h7FFFFFFF,   6'd63, ROW_BAD_RADIX, ""},
        '{31'h40000000,   6'd2,  ROW_PREDICT,   ""},
        '{31'd123456789,  6'd7,  ROW_PREDICT,   ""},
        '{31'h2AAAAAAA,   6'd3,  ROW_PREDICT,   ""},
        '{31'h55555555,   6'd35, ROW_PREDICT,   ""}
    };

    logic                  i_clk     = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [VALUE_BITS-1:0] in_value  = '0;
    logic [RADIX_W-1:0]    in_radix  = '0;
    logic                  out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [CHAR_W-1:0]     o_digit_char;
    logic                  o_last;
    logic                  o_bad_radix;

    t_digit      expected_digits [$];
    t_digit      head;
    int unsigned items_sent  = 0;
    int unsigned chars_seen  = 0;
    int unsigned bad_seen    = 0;
    int unsigned errors      = 0;
    int unsigned rx_cycle    = 0;
    int unsigned hold_left   = 0;
    bit          hold_done   = 1'b0;

    // Converter state: remainders of the latest conversion, least significant first.
    logic [REM_W-1:0] rem_digits [MAX_DIGITS];
    int unsigned      rem_count = 0;
    string            digit_glyphs = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

    integer_to_radix_digits DUT (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_value      (in_value),
        .i_radix      (in_radix),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_digit_char (o_digit_char),
        .o_last       (o_last),
        .o_bad_radix  (o_bad_radix)
    );

    always #2 i_clk = ~i_clk;

    function automatic void convert_value(input logic [VALUE_BITS-1:0] v,
                                          input logic [RADIX_W-1:0] r);
        logic [VALUE_BITS-1:0] rest;
        rest = v;
        rem_count = 0;
        if (r < RADIX_MIN || r > RADIX_MAX) begin
            expected_digits.push_back('{ch: CHAR_NONE, last: 1'b1, bad: 1'b1});
            return;
        end
        do begin
            rem_digits[rem_count] = REM_W'(rest % VALUE_BITS'(r));
            rest = rest / VALUE_BITS'(r);
            rem_count++;
        end while (rest != 0 && rem_count < MAX_DIGITS);
        for (int k = rem_count; k > 0; k--) begin
            expected_digits.push_back('{ch: CHAR_W'(digit_glyphs.getc(int'(rem_digits[k-1]))),
                                       last: (k == 1), bad: 1'b0});
        end
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: return VALUE_BITS'($urandom);
            1: return VALUE_BITS'($urandom_range(0, 40));
            2: return VALUE_BITS'($urandom) >> $urandom_range(0, VALUE_BITS - 1);
            3: return {VALUE_BITS{1'b1}} >> $urandom_range(0, VALUE_BITS - 1);
            default: return VALUE_BITS'($urandom_range(0, 2000));
        endcase
    endfunction

    function automatic logic [RADIX_W-1:0] pick_radix();
        if ($urandom_range(0, 99) < 85) begin
            return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
        end
        case ($urandom_range(0, 2))
            0: return RADIX_W'(0);
            1: return RADIX_W'(1);
            default: return RADIX_W'($urandom_range(RADIX_MAX + 1, 63));
        endcase
    endfunction

    // Hold valid and payload until the item is taken.
    task automatic offer(input logic [VALUE_BITS-1:0] v, input logic [RADIX_W-1:0] r);
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_value <= v;
        in_radix <= r;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic idle_gap(input int unsigned n);
        if (n != 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_digits.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: one long hold-off once HOLD_AT items have been sent, otherwise a rotating pattern.
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            case ((rx_cycle / 64) % 4)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (rx_cycle % 5 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (expected_digits.size() == 0) begin
                $error("unexpected character 0x%0h last=%0b bad_radix=%0b",
                       o_digit_char, o_last, o_bad_radix);
                errors++;
            end else begin
                head = expected_digits.pop_front();
                chars_seen++;
                if (o_bad_radix) bad_seen++;
                if (o_digit_char !== head.ch) begin
                    $error("digit_char: expected 0x%0h, got 0x%0h", head.ch, o_digit_char);
                    errors++;
                end
                if (o_last !== head.last) begin
                    $error("last: expected %0b, got %0b", head.last, o_last);
                    errors++;
                end
                if (o_bad_radix !== head.bad) begin
                    $error("bad_radix: expected %0b, got %0b", head.bad, o_bad_radix);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [7:0]  glyph;
        int unsigned burst_left;
        logic [VALUE_BITS-1:0] v;
        logic [RADIX_W-1:0]    r;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        foreach (DIR_ROWS[i]) begin
            offer(DIR_ROWS[i].value, DIR_ROWS[i].radix);
            case (DIR_ROWS[i].kind)
                ROW_TEXT: begin
                    for (int b = MAX_DIGITS - 1; b >= 0; b--) begin
                        glyph = DIR_ROWS[i].text[8*b +: 8];
                        if (glyph != 8'h00) begin
                            expected_digits.push_back('{ch: glyph[CHAR_W-1:0],
                                                       last: (b == 0), bad: 1'b0});
                        end
                    end
                end
                ROW_BAD_RADIX: expected_digits.push_back('{ch: CHAR_NONE, last: 1'b1,
                                                           bad: 1'b1});
                default: convert_value(DIR_ROWS[i].value, DIR_ROWS[i].radix);
            endcase
            if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 6));
        end
        wait_drained();

        burst_left = $urandom_range(1, 10);
        for (int n = 0; n < N_RANDOM; n++) begin
            // Pause the sender once mid-run until every character is out.
            if (n == N_RANDOM / 2) wait_drained();
            v = pick_value();
            r = pick_radix();
            offer(v, r);
            convert_value(v, r);
            if (burst_left == 0) begin
                idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
                burst_left = $urandom_range(1, 10);
            end else begin
                burst_left--;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d items (directed extremes, zero, bad radix, random radix 0..63),",
                 items_sent);
        $display("checked %0d characters, %0d of them bad-radix flags", chars_seen, bad_seen);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Worst case is far below this: every item at 31 digits with a stalled receiver.
    initial begin
        #6_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/itrd_pkg.sv
rtl/itrd_ram.sv
rtl/itrd_dp.sv
rtl/itrd_ctrl.sv
rtl/integer_to_radix_digits.sv
dv/integer_to_radix_digits_tb.sv
